>>> rtl/core/bksmf_pkg.sv
// shared types, codes and helpers for the bottom-k sketch multiplicity filter
// no dependencies
package bksmf_pkg;

  localparam int SKETCH_DEPTH  = 1024;
  localparam int PENDING_DEPTH = 256;
  localparam int KIW = $clog2(SKETCH_DEPTH);
  localparam int PIW = $clog2(PENDING_DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_NEW     = 3'd1,
    ST_RAISED  = 3'd2,
    ST_PENDING = 3'd3,
    ST_DROPPED = 3'd4,
    ST_DONE    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_SKETCH_SIZE = 2'd0,
    CFG_MIN_MULT    = 2'd1,
    CFG_HASH_IS_64  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLR,
    CMD_RD,
    CMD_KSCAN,
    CMD_DECIDE_K,
    CMD_PSCAN,
    CMD_DECIDE_P,
    CMD_EVICT,
    CMD_PDROP,
    CMD_APPLY
  } cmd_t;

  typedef struct packed {
    logic       k_last;
    logic       p_last;
    logic       accept;
    logic       direct;
    logic       ev_need;
    logic [1:0] op;
  } stat_t;

  typedef struct packed {
    logic        v;
    logic [63:0] h;
    logic [15:0] c;
  } kword_t;

  typedef struct packed {
    logic        v;
    logic [63:0] h;
    logic [7:0]  c;
  } pword_t;

  function automatic logic [63:0] key_of(input logic [63:0] h, input logic m64);
    key_of = m64 ? h : {32'd0, h[31:0]};
  endfunction

endpackage

>>> rtl/core/bksmf_ctrl.sv
// sequencer for the sketch filter: issues datapath commands per operation
// depends on bksmf_pkg
module bksmf_ctrl import bksmf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  res_valid,
  input  logic  res_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_CLR, S_RD, S_RWAIT, S_KSCAN, S_KWAIT, S_KDEC,
    S_PSCAN, S_PWAIT, S_PDEC, S_EVCHK, S_PDROP, S_PDWAIT, S_APPLY, S_OUT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = CMD_NONE;
    case (state)
      S_INIT: begin
        cmd = CMD_CLR;
        if (stat.k_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_INSERT: state_next = S_KSCAN;
          OP_CLEAR:  state_next = S_CLR;
          OP_READ:   state_next = S_RD;
          default:   state_next = S_OUT;
        endcase
      end
      S_CLR: begin
        cmd = CMD_CLR;
        if (stat.k_last) state_next = S_OUT;
      end
      S_RD: begin
        cmd = CMD_RD;
        state_next = S_RWAIT;
      end
      S_RWAIT: state_next = S_OUT;
      S_KSCAN: begin
        cmd = CMD_KSCAN;
        if (stat.k_last) state_next = S_KWAIT;
      end
      S_KWAIT: state_next = S_KDEC;
      S_KDEC: begin
        cmd = CMD_DECIDE_K;
        if (!stat.accept) state_next = S_OUT;
        else if (stat.direct) state_next = S_EVCHK;
        else state_next = S_PSCAN;
      end
      S_PSCAN: begin
        cmd = CMD_PSCAN;
        if (stat.p_last) state_next = S_PWAIT;
      end
      S_PWAIT: state_next = S_PDEC;
      S_PDEC: begin
        cmd = CMD_DECIDE_P;
        state_next = S_EVCHK;
      end
      S_EVCHK: begin
        if (stat.ev_need) begin
          cmd = CMD_EVICT;
          state_next = S_PDROP;
        end else begin
          cmd = CMD_APPLY;
          state_next = S_OUT;
        end
      end
      S_PDROP: begin
        cmd = CMD_PDROP;
        if (stat.p_last) state_next = S_PDWAIT;
      end
      S_PDWAIT: state_next = S_APPLY;
      S_APPLY: begin
        cmd = CMD_APPLY;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!res_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/bksmf_dp.sv
// datapath: config registers, kept and pending stores, scan trackers, results
// depends on bksmf_pkg
module bksmf_dp import bksmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic [1:0]  operation,
  input  logic [63:0] hash_value,
  input  logic [9:0]  slot_index,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [2:0]  status,
  output logic        evicted,
  output logic [63:0] out_hash,
  output logic [15:0] out_count,
  output logic        out_valid,
  output logic [10:0] entry_count,
  output logic [31:0] multiplicity_sum
);

  kword_t kmem [SKETCH_DEPTH];
  pword_t pmem [PENDING_DEPTH];

  logic [10:0]    sketch_size;
  logic [7:0]     min_mult;
  logic           hash_is_64;

  logic [1:0]     op_r;
  logic [63:0]    key_r;
  logic [KIW-1:0] slot_r;
  logic [KIW-1:0] cnt, addr_d;
  logic           k_live, p_live, d_live, r_live;
  kword_t         krd;
  pword_t         prd;

  logic           mx_found, ks_found, kf_found, ps_found, pf_found;
  logic [KIW-1:0] mx_idx, ks_idx, kf_idx;
  logic [63:0]    mx_hash, ks_hash, ps_hash, ek_r;
  logic [15:0]    mx_cnt, ks_cnt;
  logic [PIW-1:0] ps_idx, pf_idx;
  logic [7:0]     ps_cnt;

  status_t        st_r;
  logic           ev_r, ov_r;
  logic [63:0]    oh_r;
  logic [15:0]    oc_r;
  logic [KIW:0]   total;
  logic [31:0]    sum;

  logic [KIW:0]   k_eff;
  logic [7:0]     m_eff;
  logic           kwe, pwe;
  logic [KIW-1:0] kwa, kaddr, fs_idx;
  logic [PIW-1:0] pwa;
  kword_t         kwd;
  pword_t         pwd;
  logic           fs_ok, raise_live;
  logic [63:0]    krd_key, prd_key;
  logic [32:0]    sum_add1, sum_addm;

  always_comb begin
    if (sketch_size == 11'd0) k_eff = (KIW+1)'(1);
    else if (32'(sketch_size) > SKETCH_DEPTH) k_eff = (KIW+1)'(SKETCH_DEPTH);
    else k_eff = (KIW+1)'(sketch_size);
  end
  assign m_eff = (min_mult == 8'd0) ? 8'd1 : min_mult;

  assign krd_key = key_of(krd.h, hash_is_64);
  assign prd_key = key_of(prd.h, hash_is_64);

  assign stat.k_last  = (cnt == KIW'(SKETCH_DEPTH - 1));
  assign stat.p_last  = (cnt[PIW-1:0] == PIW'(PENDING_DEPTH - 1));
  assign stat.accept  = (total < k_eff) ||
                        (mx_found && (key_r < key_of(mx_hash, hash_is_64)));
  assign stat.direct  = ks_found || (m_eff == 8'd1);
  assign stat.ev_need = mx_found &&
                        (({1'b0, total} + (KIW+2)'(st_r == ST_NEW)) > {1'b0, k_eff});
  assign stat.op      = op_r;

  // new entry takes the lowest free slot, the evicted one included
  assign fs_ok  = kf_found || ev_r;
  assign fs_idx = (ev_r && (!kf_found || mx_idx < kf_idx)) ? mx_idx : kf_idx;
  assign raise_live = !(ev_r && mx_idx == ks_idx);

  assign sum_add1 = {1'b0, sum} + 33'd1;
  assign sum_addm = {1'b0, sum} + 33'(m_eff);

  assign kaddr = (cmd == CMD_RD) ? slot_r : cnt;

  always_comb begin
    kwe = 1'b0;
    kwa = cnt;
    kwd = '0;
    pwe = 1'b0;
    pwa = cnt[PIW-1:0];
    pwd = '0;
    case (cmd)
      CMD_CLR: begin
        kwe = 1'b1;
        pwe = 1'b1;
      end
      CMD_EVICT: begin
        kwe = 1'b1;
        kwa = mx_idx;
        kwd = '{v: 1'b0, h: mx_hash, c: mx_cnt};
      end
      CMD_APPLY: begin
        case (st_r)
          ST_RAISED: begin
            kwe = 1'b1;
            kwa = ks_idx;
            kwd = '{v: raise_live, h: ks_hash,
                    c: (ks_cnt == 16'hFFFF) ? ks_cnt : ks_cnt + 16'd1};
          end
          ST_NEW: begin
            kwe = fs_ok;
            kwa = fs_idx;
            kwd = '{v: 1'b1, h: key_r, c: {8'd0, m_eff}};
            pwe = ps_found;
            pwa = ps_idx;
            pwd = '{v: 1'b0, h: ps_hash, c: ps_cnt};
          end
          ST_PENDING: begin
            pwe = 1'b1;
            if (ps_found) begin
              pwa = ps_idx;
              pwd = '{v: 1'b1, h: ps_hash,
                      c: (ps_cnt == 8'hFF) ? ps_cnt : ps_cnt + 8'd1};
            end else begin
              pwa = pf_idx;
              pwd = '{v: 1'b1, h: key_r, c: 8'd1};
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // drop pending keys above the evicted key
    if (d_live && prd.v && (prd_key > ek_r)) begin
      pwe = 1'b1;
      pwa = addr_d[PIW-1:0];
      pwd = '{v: 1'b0, h: prd.h, c: prd.c};
    end
  end

  always_ff @(posedge clk) begin
    if (kwe) kmem[kwa] <= kwd;
    krd <= kmem[kaddr];
    if (pwe) pmem[pwa] <= pwd;
    prd <= pmem[cnt[PIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sketch_size <= 11'd1000;
      min_mult    <= 8'd1;
      hash_is_64  <= 1'b1;
      cnt         <= '0;
      k_live      <= 1'b0;
      p_live      <= 1'b0;
      d_live      <= 1'b0;
      r_live      <= 1'b0;
      total       <= '0;
      sum         <= '0;
      op_r        <= OP_INSERT;
      st_r        <= ST_IGNORED;
      ev_r        <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SKETCH_SIZE: sketch_size <= cfg_data;
          CFG_MIN_MULT:    min_mult    <= cfg_data[7:0];
          CFG_HASH_IS_64:  hash_is_64  <= cfg_data[0];
          default: ;
        endcase
      end

      k_live <= (cmd == CMD_KSCAN);
      p_live <= (cmd == CMD_PSCAN);
      d_live <= (cmd == CMD_PDROP);
      r_live <= (cmd == CMD_RD);
      addr_d <= cnt;

      if (k_live) begin
        if (krd.v && (!mx_found || krd_key > key_of(mx_hash, hash_is_64))) begin
          mx_found <= 1'b1;
          mx_idx   <= addr_d;
          mx_hash  <= krd.h;
          mx_cnt   <= krd.c;
        end
        if (krd.v && krd_key == key_r && !ks_found) begin
          ks_found <= 1'b1;
          ks_idx   <= addr_d;
          ks_hash  <= krd.h;
          ks_cnt   <= krd.c;
        end
        if (!krd.v && !kf_found) begin
          kf_found <= 1'b1;
          kf_idx   <= addr_d;
        end
      end
      if (p_live) begin
        if (prd.v && prd_key == key_r && !ps_found) begin
          ps_found <= 1'b1;
          ps_idx   <= addr_d[PIW-1:0];
          ps_hash  <= prd.h;
          ps_cnt   <= prd.c;
        end
        if (!prd.v && !pf_found) begin
          pf_found <= 1'b1;
          pf_idx   <= addr_d[PIW-1:0];
        end
      end
      if (r_live && krd.v) begin
        ov_r <= 1'b1;
        oh_r <= krd.h;
        oc_r <= krd.c;
      end

      case (cmd)
        CMD_LOAD: begin
          op_r     <= operation;
          key_r    <= key_of(hash_value, hash_is_64);
          slot_r   <= KIW'(slot_index);
          st_r     <= (operation == OP_CLEAR || operation == OP_READ) ? ST_DONE
                                                                     : ST_IGNORED;
          ev_r     <= 1'b0;
          ov_r     <= 1'b0;
          oh_r     <= '0;
          oc_r     <= '0;
          mx_found <= 1'b0;
          ks_found <= 1'b0;
          kf_found <= 1'b0;
          ps_found <= 1'b0;
          pf_found <= 1'b0;
          cnt      <= '0;
        end
        CMD_CLR: begin
          cnt   <= cnt + KIW'(1);
          total <= '0;
          sum   <= '0;
        end
        CMD_KSCAN, CMD_PSCAN, CMD_PDROP: cnt <= cnt + KIW'(1);
        CMD_DECIDE_K: begin
          cnt <= '0;
          if (!stat.accept) st_r <= ST_IGNORED;
          else if (ks_found) st_r <= ST_RAISED;
          else if (m_eff == 8'd1) st_r <= ST_NEW;
        end
        CMD_DECIDE_P: begin
          if (ps_found && ({1'b0, ps_cnt} + 9'd1 >= {1'b0, m_eff})) st_r <= ST_NEW;
          else if (ps_found || pf_found) st_r <= ST_PENDING;
          else st_r <= ST_DROPPED;
        end
        CMD_EVICT: begin
          cnt   <= '0;
          ev_r  <= 1'b1;
          oh_r  <= mx_hash;
          oc_r  <= mx_cnt;
          ek_r  <= key_of(mx_hash, hash_is_64);
          total <= total - (KIW+1)'(1);
          sum   <= (sum > 32'(mx_cnt)) ? sum - 32'(mx_cnt) : 32'd0;
        end
        CMD_APPLY: begin
          if (st_r == ST_RAISED) begin
            sum <= sum_add1[32] ? 32'hFFFF_FFFF : sum_add1[31:0];
          end else if (st_r == ST_NEW && fs_ok) begin
            total <= total + (KIW+1)'(1);
            sum   <= sum_addm[32] ? 32'hFFFF_FFFF : sum_addm[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign status           = st_r;
  assign evicted          = ev_r;
  assign out_hash         = oh_r;
  assign out_count        = oc_r;
  assign out_valid        = ov_r;
  assign entry_count      = 11'(total);
  assign multiplicity_sum = sum;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= SKETCH_DEPTH)
    else $error("kept total above sketch depth");

  a_scan_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(k_live && (p_live || d_live)))
    else $error("kept and pending scans overlap");

  a_evict_marks: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_EVICT |=> ev_r)
    else $error("eviction not reported");

endmodule

>>> rtl/core/bottom_k_sketch_multiplicity_filter.sv
// top level of the bottom-k sketch with multiplicity filter
// depends on bksmf_pkg, bksmf_ctrl, bksmf_dp
// insert: full scan of the kept store, plus a pending scan when a new key needs
//   counting, plus a pending drop sweep on eviction, plus an update step when accepted
//   and a step to present the result
// clear: a sweep of the kept and pending stores; read: one kept read; one item in flight at a time
// after reset a clearing pass runs before the first item
module bottom_k_sketch_multiplicity_filter import bksmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] hash_value,
  input  logic [9:0]  slot_index,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic        evicted,
  output logic [63:0] out_hash,
  output logic [15:0] out_count,
  output logic        out_valid,
  output logic [10:0] entry_count,
  output logic [31:0] multiplicity_sum
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bksmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bksmf_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .operation        (operation),
    .hash_value       (hash_value),
    .slot_index       (slot_index),
    .cmd              (cmd),
    .stat             (stat),
    .status           (status),
    .evicted          (evicted),
    .out_hash         (out_hash),
    .out_count        (out_count),
    .out_valid        (out_valid),
    .entry_count      (entry_count),
    .multiplicity_sum (multiplicity_sum)
  );

endmodule

>>> dv/tb_bottom_k_sketch_multiplicity_filter.sv
// testbench for bottom_k_sketch_multiplicity_filter: directed rows, then random phases
// depends on bksmf_pkg and the rtl top level; own scoreboard model of the sketch
module tb_bottom_k_sketch_multiplicity_filter;
  import bksmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    status_t     st;
    logic        ev;
    logic [63:0] hash;
    logic [15:0] cnt;
    logic        ov;
    logic [10:0] entries;
    logic [31:0] msum;
  } sketch_res_t;

  typedef struct {
    op_t         op;
    logic [63:0] hash;
    logic [9:0]  slot;
    bit          typed;
    sketch_res_t want;
  } stim_row_t;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  operation;
  logic [63:0] hash_value;
  logic [9:0]  slot_index;
  logic        res_valid, res_stall;
  logic [2:0]  status;
  logic        evicted;
  logic [63:0] out_hash;
  logic [15:0] out_count;
  logic        out_valid;
  logic [10:0] entry_count;
  logic [31:0] multiplicity_sum;

  bottom_k_sketch_multiplicity_filter dut (.*);

  // scoreboard copy of the sketch
  logic [10:0] k_reg;
  logic [7:0]  m_reg;
  logic        wide_reg;
  logic [63:0] kept_h [SKETCH_DEPTH];
  logic [15:0] kept_c [SKETCH_DEPTH];
  bit          kept_v [SKETCH_DEPTH];
  logic [63:0] pend_h [PENDING_DEPTH];
  logic [7:0]  pend_c [PENDING_DEPTH];
  bit          pend_v [PENDING_DEPTH];
  int          kept_n;
  logic [31:0] csum;

  sketch_res_t expected_q[$];
  int          errors = 0;
  bit          idling = 1;
  int          quiet = 0;
  logic [63:0] pool[16];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] mask_key(logic [63:0] h);
    return wide_reg ? h : {32'd0, h[31:0]};
  endfunction

  function automatic void wipe_sketch();
    foreach (kept_v[i]) kept_v[i] = 0;
    foreach (pend_v[i]) pend_v[i] = 0;
    kept_n = 0;
    csum = 0;
  endfunction

  function automatic void bump_sum(logic [31:0] v);
    logic [32:0] s;
    s = {1'b0, csum} + {1'b0, v};
    csum = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic sketch_res_t predict_sketch(logic [1:0] op, logic [63:0] h,
                                                 logic [9:0] slot);
    sketch_res_t r;
    int k, m, mx, ks, ps, fs;
    logic [63:0] key, ek;
    bit adds;
    r = '0;
    if (op == OP_CLEAR) begin
      wipe_sketch();
      r.st = ST_DONE;
    end else if (op == OP_READ) begin
      r.st = ST_DONE;
      if (kept_v[slot]) begin
        r.ov = 1;
        r.hash = kept_h[slot];
        r.cnt = kept_c[slot];
      end
    end else if (op == OP_INSERT) begin
      key = mask_key(h);
      k = (k_reg == 0) ? 1 : (k_reg > SKETCH_DEPTH) ? SKETCH_DEPTH : k_reg;
      m = (m_reg == 0) ? 1 : m_reg;
      mx = -1;
      for (int i = 0; i < SKETCH_DEPTH; i++)
        if (kept_v[i] && (mx < 0 || mask_key(kept_h[i]) > mask_key(kept_h[mx]))) mx = i;
      if (kept_n < k || (mx >= 0 && key < mask_key(kept_h[mx]))) begin
        ks = -1;
        ps = -1;
        adds = 0;
        for (int i = 0; i < SKETCH_DEPTH && ks < 0; i++)
          if (kept_v[i] && mask_key(kept_h[i]) == key) ks = i;
        if (ks >= 0) r.st = ST_RAISED;
        else if (m == 1) begin
          r.st = ST_NEW;
          adds = 1;
        end else begin
          for (int i = 0; i < PENDING_DEPTH && ps < 0; i++)
            if (pend_v[i] && mask_key(pend_h[i]) == key) ps = i;
          if (ps >= 0 && int'(pend_c[ps]) + 1 >= m) begin
            r.st = ST_NEW;
            adds = 1;
          end else if (ps >= 0) r.st = ST_PENDING;
          else begin
            for (int i = 0; i < PENDING_DEPTH && ps < 0; i++)
              if (!pend_v[i]) ps = i;
            r.st = (ps >= 0) ? ST_PENDING : ST_DROPPED;
          end
        end
        if (kept_n + int'(adds) > k && mx >= 0) begin
          ek = mask_key(kept_h[mx]);
          r.ev = 1;
          r.hash = kept_h[mx];
          r.cnt = kept_c[mx];
          kept_v[mx] = 0;
          kept_n--;
          csum = (csum > 32'(kept_c[mx])) ? csum - 32'(kept_c[mx]) : 32'd0;
          for (int i = 0; i < PENDING_DEPTH; i++)
            if (pend_v[i] && mask_key(pend_h[i]) > ek) pend_v[i] = 0;
        end
        if (r.st == ST_RAISED) begin
          if (kept_c[ks] != 16'hFFFF) kept_c[ks]++;
          bump_sum(32'd1);
        end else if (r.st == ST_NEW) begin
          fs = -1;
          for (int i = 0; i < SKETCH_DEPTH && fs < 0; i++)
            if (!kept_v[i]) fs = i;
          if (fs >= 0) begin
            kept_v[fs] = 1;
            kept_h[fs] = key;
            kept_c[fs] = 16'(m);
            kept_n++;
            bump_sum(32'(m));
          end
          if (ps >= 0) pend_v[ps] = 0;
        end else if (r.st == ST_PENDING) begin
          if (!pend_v[ps]) begin
            pend_v[ps] = 1;
            pend_h[ps] = key;
            pend_c[ps] = 8'd1;
          end else if (pend_c[ps] != 8'hFF) pend_c[ps]++;
        end
      end
    end
    r.entries = 11'(kept_n);
    r.msum = csum;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  // optional sender idle burst, then one transfer; the expectation is queued at acceptance
  task automatic send_item(logic [1:0] op, logic [63:0] h, logic [9:0] slot,
                           bit typed, sketch_res_t want);
    sketch_res_t p;
    @(negedge clk);
    if (idling && $urandom_range(0, 2) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    operation = op;
    hash_value = h;
    slot_index = slot;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    p = predict_sketch(op, h, slot);
    expected_q.push_back(typed ? want : p);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [10:0] val);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SKETCH_SIZE: k_reg = val;
      CFG_MIN_MULT:    m_reg = val[7:0];
      default:         wide_reg = val[0];
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic void fill_pool();
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    pool[0] = '0;
    pool[1] = '1;
  endfunction

  function automatic logic [63:0] pick_hash();
    logic [63:0] h;
    if ($urandom_range(0, 9) < 7) begin
      h = pool[$urandom_range(0, 15)];
      // same low half with other upper bits aliases in 32-bit mode
      if (!wide_reg && $urandom_range(0, 1)) h[63:32] = $urandom;
    end else h = {$urandom, $urandom};
    return h;
  endfunction

  task automatic random_phase(int n, int k_hint);
    int r;
    fill_pool();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) send_item(OP_INSERT, pick_hash(), 10'($urandom), 0, '0);
      else if (r < 94)
        send_item(OP_READ, {$urandom, $urandom},
                  ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                              : 10'($urandom_range(0, k_hint + 2)), 0, '0);
      else if (r < 97) send_item(OP_CLEAR, {$urandom, $urandom}, 10'($urandom), 0, '0);
      else send_item(op_t'(2'd3), {$urandom, $urandom}, 10'($urandom), 0, '0);
    end
  endtask

  function automatic sketch_res_t mk(status_t st, logic ev, logic [63:0] h, logic [15:0] c,
                                     logic ov, logic [10:0] n, logic [31:0] s);
    return '{st, ev, h, c, ov, n, s};
  endfunction

  // result side: random stall bursts, compare on transfer
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idling && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 4);
    res_stall = (stall_left > 0);
  end

  always @(posedge clk) begin
    sketch_res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'd1, 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (status !== e.st) report_mismatch("status", status, e.st);
        if (evicted !== e.ev) report_mismatch("evicted", evicted, e.ev);
        if (out_hash !== e.hash) report_mismatch("out_hash", out_hash, e.hash);
        if (out_count !== e.cnt) report_mismatch("out_count", out_count, e.cnt);
        if (out_valid !== e.ov) report_mismatch("out_valid", out_valid, e.ov);
        if (entry_count !== e.entries) report_mismatch("entry_count", entry_count, e.entries);
        if (multiplicity_sum !== e.msum)
          report_mismatch("multiplicity_sum", multiplicity_sum, e.msum);
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("tb_bottom_k_sketch_multiplicity_filter: FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    rst = 1;
    cfg_valid = 0;
    cfg_index = CFG_SKETCH_SIZE;
    cfg_data = '0;
    in_valid = 0;
    operation = OP_INSERT;
    hash_value = '0;
    slot_index = '0;
    k_reg = 11'd1000;
    m_reg = 8'd1;
    wide_reg = 1;
    wipe_sketch();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset settings: extremes of hash and slot, unknown op, clear
    rows = '{
      '{OP_READ, '0, 10'd0, 1, mk(ST_DONE, 0, '0, 0, 0, 0, 0)},
      '{op_t'(2'd3), '1, '1, 1, mk(ST_IGNORED, 0, '0, 0, 0, 0, 0)},
      '{OP_INSERT, '0, '0, 1, mk(ST_NEW, 0, '0, 0, 0, 1, 1)},
      '{OP_INSERT, '0, '1, 1, mk(ST_RAISED, 0, '0, 0, 0, 1, 2)},
      '{OP_INSERT, '1, '0, 1, mk(ST_NEW, 0, '0, 0, 0, 2, 3)},
      '{OP_READ, '1, 10'd0, 1, mk(ST_DONE, 0, '0, 2, 1, 2, 3)},
      '{OP_READ, '0, 10'd1, 1, mk(ST_DONE, 0, '1, 1, 1, 2, 3)},
      '{OP_READ, '0, 10'd1023, 1, mk(ST_DONE, 0, '0, 0, 0, 2, 3)},
      '{OP_INSERT, 64'h5555_AAAA_0F0F_F0F0, '0, 0, '0},
      '{OP_INSERT, 64'hAAAA_5555_F0F0_0F0F, '0, 0, '0},
      '{OP_READ, '0, 10'd2, 0, '0},
      '{OP_CLEAR, '1, '1, 1, mk(ST_DONE, 0, '0, 0, 0, 0, 0)}
    };
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.op, row.hash, row.slot, row.typed, row.want);
    end

    // k of zero acts as one, multiplicity zero as one: a smaller key evicts
    write_reg(CFG_SKETCH_SIZE, 11'd0);
    write_reg(CFG_MIN_MULT, 11'd0);
    rows = '{
      '{OP_INSERT, 64'd10, '0, 1, mk(ST_NEW, 0, '0, 0, 0, 1, 1)},
      '{OP_INSERT, 64'd5, '0, 1, mk(ST_NEW, 1, 64'd10, 1, 0, 1, 1)},
      '{OP_INSERT, 64'd7, '0, 1, mk(ST_IGNORED, 0, '0, 0, 0, 1, 1)}
    };
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.op, row.hash, row.slot, row.typed, row.want);
    end
    random_phase(100, 1);

    write_reg(CFG_SKETCH_SIZE, 11'd4);
    write_reg(CFG_MIN_MULT, 11'd1);
    random_phase(200, 4);

    write_reg(CFG_SKETCH_SIZE, 11'd8);
    write_reg(CFG_MIN_MULT, 11'd3);
    write_reg(CFG_HASH_IS_64, 11'd0);
    random_phase(300, 8);

    // oversized k acts as the full depth; fill the pending store until it drops
    write_reg(CFG_SKETCH_SIZE, 11'd2047);
    write_reg(CFG_MIN_MULT, 11'd255);
    write_reg(CFG_HASH_IS_64, 11'd1);
    send_item(OP_CLEAR, '0, '0, 0, '0);
    for (int i = 0; i < 262; i++) send_item(OP_INSERT, {$urandom, $urandom}, '0, 0, '0);
    random_phase(40, 8);

    write_reg(CFG_SKETCH_SIZE, 11'd16);
    write_reg(CFG_MIN_MULT, 11'd2);
    send_item(OP_CLEAR, '0, '0, 0, '0);
    random_phase(300, 16);

    write_reg(CFG_SKETCH_SIZE, 11'd3);
    write_reg(CFG_MIN_MULT, 11'd4);
    write_reg(CFG_HASH_IS_64, 11'd0);
    random_phase(250, 3);
    idling = 0;
    random_phase(150, 3);

    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb_bottom_k_sketch_multiplicity_filter: PASS");
    else $display("tb_bottom_k_sketch_multiplicity_filter: FAIL");
    $finish;
  end
endmodule
